FILE: rtl/core/affinv_pkg.sv
// Shared types and constants for the affine 2D inverse core.
package affinv_pkg;

  // Number of quotients formed per matrix (r00, r01, r10, r11, rtx, rty)
  localparam int NUM_LANES = 6;

  // Sideband that travels with each matrix through the pipeline
  typedef struct packed {
    logic valid;
    logic singular;
  } affinv_ctl_t;

endpackage

FILE: rtl/core/affine_2d_inverse_core.sv
// Top level of the affine 2D inverse core: products, determinant and six division lanes.
//
// Usage:
//   The slave channel takes one 2x3 affine matrix per beat on s_tdata
//   (m00, m01, m10, m11, tx, ty, signed fixed point). The master channel
//   returns the inverse (r00, r01, r10, r11, rtx, rty) on m_tdata and the
//   singular flag on m_tuser, one beat per input beat, in order.
//   Results are rounded to nearest, ties away from zero, and saturated.
//   A zero determinant gives all-zero results with singular set.
// Pipeline: three front stages, one rounding setup stage, ELEM_WIDTH division
//   cells and one saturation stage lie between input beat and output beat.
// Throughput: one matrix per cycle while the output is not stalled; each lane has ELEM_WIDTH division
//   cells, each resolving one quotient bit and passing its remainder on.
// Stall: the whole pipeline holds while m_tvalid is high and m_tready is
//   low; s_tready follows that same condition.
// Reset: rst clears every valid flag and holds s_tready low; no result is
//   pending afterwards.
module affine_2d_inverse_core
  import affinv_pkg::*;
#(
  parameter int FRAC_BITS  = 16,
  parameter int ELEM_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // m00, m01, m10, m11, tx, ty from the lowest bit up
  input  logic [((6*ELEM_WIDTH+7)/8)*8-1:0]   s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // r00, r01, r10, r11, rtx, rty from the lowest bit up
  output logic [((6*ELEM_WIDTH+7)/8)*8-1:0]   m_tdata,
  // singular
  output logic                                m_tuser
);

  localparam int W      = ELEM_WIDTH;
  localparam int F      = FRAC_BITS;
  localparam int DATA_W = ((6 * W + 7) / 8) * 8;
  localparam int NW     = ((W + 2 * F) > (2 * W + F + 1)) ? (W + 2 * F) : (2 * W + F + 1);

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en && !rst;

  // Unpack input beat
  logic signed [W-1:0] in_a, in_b, in_c, in_d, in_tx, in_ty;
  assign in_a  = $signed(s_tdata[0*W +: W]);
  assign in_b  = $signed(s_tdata[1*W +: W]);
  assign in_c  = $signed(s_tdata[2*W +: W]);
  assign in_d  = $signed(s_tdata[3*W +: W]);
  assign in_tx = $signed(s_tdata[4*W +: W]);
  assign in_ty = $signed(s_tdata[5*W +: W]);

  // Stage 1: products
  logic                  v1;
  logic signed [W-1:0]   a1, b1, c1, d1;
  logic signed [2*W-1:0] p_ad, p_cb, p_cty, p_txd, p_txb, p_aty;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1    <= in_a;
      b1    <= in_b;
      c1    <= in_c;
      d1    <= in_d;
      p_ad  <= in_a * in_d;
      p_cb  <= in_c * in_b;
      p_cty <= in_c * in_ty;
      p_txd <= in_tx * in_d;
      p_txb <= in_tx * in_b;
      p_aty <= in_a * in_ty;
    end
  end

  // Stage 2: determinant and scaled numerators
  logic                 v2;
  logic signed [2*W:0]  det2;
  logic signed [NW:0]   num2 [NUM_LANES];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      det2    <= (2*W+1)'(p_ad) - (2*W+1)'(p_cb);
      num2[0] <= (NW+1)'(d1) <<< (2 * F);
      num2[1] <= (-(NW+1)'(b1)) <<< (2 * F);
      num2[2] <= (-(NW+1)'(c1)) <<< (2 * F);
      num2[3] <= (NW+1)'(a1) <<< (2 * F);
      num2[4] <= ((NW+1)'(p_cty) - (NW+1)'(p_txd)) <<< F;
      num2[5] <= ((NW+1)'(p_txb) - (NW+1)'(p_aty)) <<< F;
    end
  end

  // Stage 3: magnitudes, signs and singular check
  affinv_ctl_t  ctl3;
  logic [2*W:0] dmag3;
  logic [NW-1:0] nmag3 [NUM_LANES];
  logic          neg3  [NUM_LANES];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl3 <= '0;
    end else if (en) begin
      ctl3.valid    <= v2;
      ctl3.singular <= (det2 == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dmag3 <= det2[2*W] ? (~det2 + 1'b1) : det2;
      for (int k = 0; k < NUM_LANES; k++) begin
        nmag3[k] <= num2[k][NW] ? NW'(-num2[k]) : num2[k][NW-1:0];
        neg3[k]  <= num2[k][NW] ^ det2[2*W];
      end
    end
  end

  // Division lanes
  affinv_ctl_t  ctl_o;
  logic [W-1:0] res [NUM_LANES];

  for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
    if (k == 0) begin : g_lead
      affinv_lane #(.W(W), .NW(NW)) u_lane (
        .clk     (clk),
        .rst     (rst),
        .en      (en),
        .ctl_in  (ctl3),
        .neg_in  (neg3[k]),
        .n_in    (nmag3[k]),
        .d_in    (dmag3),
        .ctl_out (ctl_o),
        .res     (res[k])
      );
    end else begin : g_rest
      affinv_lane #(.W(W), .NW(NW)) u_lane (
        .clk     (clk),
        .rst     (rst),
        .en      (en),
        .ctl_in  (ctl3),
        .neg_in  (neg3[k]),
        .n_in    (nmag3[k]),
        .d_in    (dmag3),
        .ctl_out (),
        .res     (res[k])
      );
    end
  end

  // Output beat
  assign m_tvalid = ctl_o.valid;
  assign m_tuser  = ctl_o.singular;
  assign m_tdata  = DATA_W'({res[5], res[4], res[3], res[2], res[1], res[0]});

endmodule

FILE: rtl/core/affinv_cell.sv
// One restoring-division cell: resolves one quotient bit and hands on to the next cell.
module affinv_cell
  import affinv_pkg::*;
#(
  parameter int DW = 66,
  parameter int QB = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  affinv_ctl_t   ctl_in,
  input  logic          neg_in,
  input  logic          over_in,
  input  logic [DW-1:0] d2_in,
  input  logic [DW-1:0] rem_in,
  input  logic [QB-1:0] low_in,
  input  logic [QB-1:0] q_in,
  output affinv_ctl_t   ctl_out,
  output logic          neg_out,
  output logic          over_out,
  output logic [DW-1:0] d2_out,
  output logic [DW-1:0] rem_out,
  output logic [QB-1:0] low_out,
  output logic [QB-1:0] q_out
);

  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;
  logic [DW-1:0] rem_next;

  // Shift in the next dividend bit, compare and subtract
  always_comb begin
    trial    = {rem_in, low_in[QB-1]};
    diff     = trial - {1'b0, d2_in};
    ge       = (trial >= {1'b0, d2_in});
    rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out <= ctl_in;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (en) begin
      neg_out  <= neg_in;
      over_out <= over_in;
      d2_out   <= d2_in;
      rem_out  <= rem_next;
      low_out  <= {low_in[QB-2:0], 1'b0};
      q_out    <= {q_in[QB-2:0], ge};
    end
  end

endmodule

FILE: rtl/core/affinv_lane.sv
// One quotient lane: rounding setup, a chain of division cells, then saturation.
module affinv_lane
  import affinv_pkg::*;
#(
  parameter int W  = 32,
  parameter int NW = 81
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  affinv_ctl_t   ctl_in,
  input  logic          neg_in,
  input  logic [NW-1:0] n_in,
  input  logic [2*W:0]  d_in,
  output affinv_ctl_t   ctl_out,
  output logic [W-1:0]  res
);

  localparam int QB = W;
  localparam int DW = 2 * W + 2;
  localparam int TW = NW + 2;
  localparam int HW = TW - QB;
  localparam int CW = (HW > DW) ? HW : DW;

  // Rounding setup: quotient of (2n + d) / 2d, top part checked for overflow
  logic [TW-1:0] top;
  logic [DW-1:0] d2;
  logic [HW-1:0] hi;
  logic          over0;

  always_comb begin
    top   = {1'b0, n_in, 1'b0} + TW'(d_in);
    d2    = {d_in, 1'b0};
    hi    = top[TW-1:QB];
    over0 = (CW'(hi) >= CW'(d2));
  end

  affinv_ctl_t   ctl_c  [QB+1];
  logic          neg_c  [QB+1];
  logic          over_c [QB+1];
  logic [DW-1:0] d2_c   [QB+1];
  logic [DW-1:0] rem_c  [QB+1];
  logic [QB-1:0] low_c  [QB+1];
  logic [QB-1:0] q_c    [QB+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_c[0] <= '0;
    end else if (en) begin
      ctl_c[0] <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_c[0]  <= neg_in;
      over_c[0] <= over0;
      d2_c[0]   <= d2;
      rem_c[0]  <= over0 ? '0 : DW'(hi);
      low_c[0]  <= top[QB-1:0];
      q_c[0]    <= '0;
    end
  end

  // Chain of cells, one quotient bit each
  for (genvar i = 0; i < QB; i++) begin : g_cell
    affinv_cell #(.DW(DW), .QB(QB)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .ctl_in   (ctl_c[i]),
      .neg_in   (neg_c[i]),
      .over_in  (over_c[i]),
      .d2_in    (d2_c[i]),
      .rem_in   (rem_c[i]),
      .low_in   (low_c[i]),
      .q_in     (q_c[i]),
      .ctl_out  (ctl_c[i+1]),
      .neg_out  (neg_c[i+1]),
      .over_out (over_c[i+1]),
      .d2_out   (d2_c[i+1]),
      .rem_out  (rem_c[i+1]),
      .low_out  (low_c[i+1]),
      .q_out    (q_c[i+1])
    );
  end

  // Saturate, apply sign, zero on a singular matrix
  logic [W-1:0] limit;
  logic [W-1:0] qsat;
  logic [W-1:0] res_next;

  always_comb begin
    limit    = neg_c[QB] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    qsat     = (over_c[QB] || (q_c[QB] > limit)) ? limit : q_c[QB];
    res_next = neg_c[QB] ? (~qsat + 1'b1) : qsat;
    if (ctl_c[QB].singular) begin
      res_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out <= ctl_c[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= res_next;
    end
  end

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the affine 2D inverse core.
`timescale 1ns / 1ps

module testbench;
  import affinv_pkg::*;

  localparam int FRAC_BITS  = 16;
  localparam int ELEM_WIDTH = 32;
  localparam int DATA_W     = ((6*ELEM_WIDTH+7)/8)*8;
  localparam int PIPE_LAT   = ELEM_WIDTH + 5;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RAND_ITEMS  = 750;
  localparam int HOLD_CYCLES = 400;
  localparam logic signed [31:0] ELEM_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] ELEM_MIN = 32'sh80000000;
  localparam logic signed [31:0] ONE      = 32'sh00010000;

  typedef logic signed [191:0] wide_t;

  typedef struct {
    logic signed [31:0] m00, m01, m10, m11, tx, ty;
  } matrix_t;

  typedef struct {
    logic [31:0] r00, r01, r10, r11, rtx, rty;
    logic        singular;
  } inverse_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [DATA_W-1:0] s_tdata = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [DATA_W-1:0] m_tdata;
  logic              m_tuser;

  matrix_t  matrix_q[$];
  inverse_t inverse_q[$];
  int       fail_cnt = 0;
  int       result_cnt = 0;
  int       cycle_cnt = 0;
  int       hold_left = 0;
  bit       hold_done = 1'b0;
  bit       in_beat = 1'b0;
  bit       out_beat = 1'b0;
  int       tx_wait = 0;
  int       rx_wait = 0;

  affine_2d_inverse_core #(
    .FRAC_BITS (FRAC_BITS),
    .ELEM_WIDTH(ELEM_WIDTH)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  always #6 clk = ~clk;

  // Rounded (half away from zero) and saturated quotient num/den
  function automatic logic [31:0] round_div_sat(wide_t num, wide_t den);
    logic [191:0] n, d, q;
    bit           neg;
    neg = num[191] ^ den[191];
    n = num[191] ? -num : num;
    d = den[191] ? -den : den;
    q = (2 * n + d) / (2 * d);
    if (neg) begin
      if (q > 192'h80000000) q = 192'h80000000;
      return -q[31:0];
    end else begin
      if (q > 192'h7fffffff) q = 192'h7fffffff;
      return q[31:0];
    end
  endfunction

  function automatic inverse_t invert_affine(matrix_t m);
    inverse_t r;
    wide_t    a, b, c, d, tx, ty, det;
    a = m.m00; b = m.m01; c = m.m10; d = m.m11; tx = m.tx; ty = m.ty;
    det = a * d - c * b;
    r = '{default: '0};
    if (det == 0) begin
      r.singular = 1'b1;
      return r;
    end
    r.r00 = round_div_sat(d <<< (2*FRAC_BITS), det);
    r.r01 = round_div_sat((-b) <<< (2*FRAC_BITS), det);
    r.r10 = round_div_sat((-c) <<< (2*FRAC_BITS), det);
    r.r11 = round_div_sat(a <<< (2*FRAC_BITS), det);
    r.rtx = round_div_sat((c * ty - tx * d) <<< FRAC_BITS, det);
    r.rty = round_div_sat((tx * b - a * ty) <<< FRAC_BITS, det);
    return r;
  endfunction

  // Gaps come in stretches: one busy stretch with no gaps after every two stretches of random gaps
  function automatic int draw_gap();
    if (((cycle_cnt / 700) % 3) == 1) return 0;
    return $urandom_range(0, 11);
  endfunction

  function automatic logic signed [31:0] rand_elem();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h0007ffff)) - 32'sh00040000;
      2: return $signed($urandom_range(0, 32'h000001ff)) - 32'sh00000100;
      default: return $signed($urandom_range(0, 32'h03ffffff)) - 32'sh02000000;
    endcase
  endfunction

  task automatic add_matrix(logic signed [31:0] m00, m01, m10, m11, tx, ty);
    matrix_t m;
    m = '{m00, m01, m10, m11, tx, ty};
    matrix_q.push_back(m);
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch on %s: got %h expected %h (result %0d)", what, got, want, result_cnt);
    fail_cnt++;
  endtask

  // Stimulus and end of run
  initial begin
    matrix_t m;
    int      k;
    // directed: singular, identity, extremes, tiny and negative determinants, ties
    add_matrix(0, 0, 0, 0, 0, 0);
    add_matrix(ONE, 0, 0, ONE, 0, 0);
    add_matrix(ONE, 0, 0, ONE, ELEM_MAX, ELEM_MIN);
    add_matrix(ELEM_MAX, 0, 0, ELEM_MAX, ELEM_MIN, ELEM_MAX);
    add_matrix(ELEM_MIN, 0, 0, ELEM_MIN, ELEM_MAX, ELEM_MAX);
    add_matrix(ELEM_MIN, ELEM_MAX, ELEM_MAX, ELEM_MIN, ELEM_MIN, ELEM_MIN);
    add_matrix(1, 0, 0, 1, 1, -1);
    add_matrix(-1, 0, 0, 1, 5, 7);
    add_matrix(0, ONE, ONE, 0, ONE, -ONE);
    add_matrix(2*ONE, 4*ONE, ONE, 2*ONE, 3, 3);
    add_matrix(ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX, 1, 1);
    add_matrix(2*ONE, 0, 0, 2*ONE, 1, -1);
    add_matrix(3*ONE, 0, 0, 3*ONE, ONE, 2);
    add_matrix(-2*ONE, 0, 0, -2*ONE, 3, -3);
    add_matrix(ONE, ONE, -ONE, ONE, -1, 32'sh00018000);
    add_matrix(ELEM_MAX, ELEM_MIN, 1, -1, ELEM_MAX, ELEM_MIN);
    add_matrix(-1, -1, 32'shffffffff, 32'shfffffffe, 0, ELEM_MAX);
    add_matrix(32'sh00008000, 0, 0, 32'sh00008000, ELEM_MIN, 1);
    // random: mostly full-rank mixes, some forced singular
    for (k = 0; k < RAND_ITEMS; k++) begin
      m = '{rand_elem(), rand_elem(), rand_elem(), rand_elem(), rand_elem(), rand_elem()};
      if ($urandom_range(0, 15) == 0) begin
        m.m10 = m.m00 >>> 1 <<< 1;
        m.m00 = m.m10;
        m.m11 = m.m01;
      end
      matrix_q.push_back(m);
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    wait (matrix_q.size() == 0 && !s_tvalid && inverse_q.size() == 0);
    repeat (PIPE_LAT + 8) @(posedge clk);
    if (fail_cnt == 0 && inverse_q.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("testbench NOT OK");
      $finish;
    end
  end

  // Input beats feed the predictor
  always @(posedge clk) begin
    matrix_t m;
    in_beat <= s_tvalid && s_tready && !rst;
    if (s_tvalid && s_tready && !rst) begin
      m.m00 = s_tdata[31:0];    m.m01 = s_tdata[63:32];
      m.m10 = s_tdata[95:64];   m.m11 = s_tdata[127:96];
      m.tx  = s_tdata[159:128]; m.ty  = s_tdata[191:160];
      inverse_q.push_back(invert_affine(m));
    end
  end

  // Sender: one drawn gap per matrix
  always @(negedge clk) begin
    matrix_t m;
    bit      nvalid;
    nvalid = s_tvalid;
    if (!rst) begin
      if (s_tvalid && !in_beat) begin
        nvalid = 1'b1;
      end else if (tx_wait > 0) begin
        nvalid = 1'b0;
        tx_wait <= tx_wait - 1;
      end else if (matrix_q.size() > 0) begin
        m = matrix_q.pop_front();
        s_tdata <= {m.ty, m.tx, m.m11, m.m10, m.m01, m.m00};
        nvalid = 1'b1;
        tx_wait <= draw_gap();
      end else begin
        nvalid = 1'b0;
      end
      s_tvalid <= nvalid;
    end
  end

  // One long receiver hold once 150 results have been received, so the input stalls
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && result_cnt >= 150) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // Receiver: one drawn stall per result
  always @(negedge clk) begin
    int w;
    w = rx_wait;
    if (out_beat) w = draw_gap();
    else if (w > 0) w = w - 1;
    rx_wait <= w;
    m_tready <= !rst && w == 0 && hold_left == 0;
  end

  // Output beats checked against the oldest prediction
  always @(posedge clk) begin
    inverse_t want;
    out_beat <= m_tvalid && m_tready && !rst;
    if (m_tvalid && m_tready && !rst) begin
      if (inverse_q.size() == 0) begin
        report("unexpected beat", m_tdata[31:0], '0);
      end else begin
        want = inverse_q.pop_front();
        if (m_tdata[31:0]    !== want.r00) report("r00", m_tdata[31:0], want.r00);
        if (m_tdata[63:32]   !== want.r01) report("r01", m_tdata[63:32], want.r01);
        if (m_tdata[95:64]   !== want.r10) report("r10", m_tdata[95:64], want.r10);
        if (m_tdata[127:96]  !== want.r11) report("r11", m_tdata[127:96], want.r11);
        if (m_tdata[159:128] !== want.rtx) report("rtx", m_tdata[159:128], want.rtx);
        if (m_tdata[191:160] !== want.rty) report("rty", m_tdata[191:160], want.rty);
        if (m_tuser !== want.singular) report("singular", m_tuser, want.singular);
      end
      result_cnt <= result_cnt + 1;
    end
  end

endmodule

FILE: filelist.f
rtl/core/affinv_pkg.sv
rtl/core/affinv_cell.sv
rtl/core/affinv_lane.sv
rtl/core/affine_2d_inverse_core.sv
tb/sv/testbench.sv
